// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pcmf_pkg.sv =====
// Package for the PCM byte to float sample converter.
// Holds width codes, field widths and the conversion functions; no dependencies.
`default_nettype none
package pcmf_pkg;

    localparam int MAX_CHANNELS = 8;

    typedef enum logic [2:0] {
        WIDTH_8  = 3'd0,
        WIDTH_16 = 3'd1,
        WIDTH_24 = 3'd2,
        WIDTH_32 = 3'd3,
        WIDTH_64 = 3'd4
    } width_code_t;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_FLOAT = 2'd1;
    localparam logic [1:0] REG_CHANS = 2'd2;

    // Bytes per sample for a width code; zero for codes that mean nothing.
    function automatic logic [3:0] width_bytes(input logic [2:0] code);
        logic [3:0] n;
        case (code)
            WIDTH_8:  n = 4'd1;
            WIDTH_16: n = 4'd2;
            WIDTH_24: n = 4'd3;
            WIDTH_32: n = 4'd4;
            WIDTH_64: n = 4'd8;
            default:  n = 4'd0;
        endcase
        return n;
    endfunction

    // Sign and magnitude divided by 2^k, rounded to nearest even, as float32.
    function automatic logic [31:0] int_to_f32(input logic neg, input logic [31:0] mag,
                                               input logic [4:0] k);
        logic [4:0]  p;
        logic [31:0] norm;
        logic [23:0] mant;
        logic        lsb;
        logic        rnd;
        logic        stk;
        logic [32:0] sum;
        p = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
                p = 5'(i);
        end
        norm = mag << (5'd31 - p);
        mant = norm[31:8];
        lsb = norm[8];
        rnd = norm[7];
        stk = |norm[6:0];
        sum = {9'd0, mant} + {32'd0, rnd & (stk | lsb)};
        // The hidden bit and any carry out of the mantissa add to the exponent below.
        sum = sum + ({25'd0, p} + 33'd126 - {28'd0, k}) * 33'd8388608;
        if (mag == 32'd0)
            return 32'd0;
        return {neg, 31'd0} | sum[31:0];
    endfunction

    // Shift right by sh with round to nearest even (sh up to 63).
    function automatic logic [31:0] shr_rne(input logic [52:0] v, input logic [5:0] sh);
        logic [52:0]  q;
        logic [115:0] ext;
        logic         half;
        logic         low;
        ext = {v, 63'd0} >> sh;
        q = ext[115:63];
        half = ext[62];
        low = |ext[61:0];
        return 32'(q) + {31'd0, half & (low | q[0])};
    endfunction

    // Narrow a float64 to float32.
    function automatic logic [31:0] f64_to_f32(input logic [63:0] b);
        logic [31:0] s;
        logic [10:0] e;
        logic [51:0] m;
        logic [52:0] full;
        logic [11:0] sh;
        s = {b[63], 31'd0};
        e = b[62:52];
        m = b[51:0];
        full = {1'b1, m};
        sh = 12'd926 - {1'b0, e};
        if (e == 11'h7FF)
            return (m == 52'd0) ? (s | 32'h7F800000) : (s | 32'h7FC00000 | 32'(m >> 29));
        if (e == 11'd0)
            return s;
        if (e > 11'd1150)
            return s | 32'h7F800000;
        if (e >= 11'd897)
            return s | (({21'd0, e} - 32'd897) << 23) + shr_rne(full, 6'd29);
        if (e < 11'd872)
            return s;
        return s | shr_rne(full, sh[5:0]);
    endfunction

    // Full conversion of one assembled sample.
    function automatic logic [31:0] convert(input logic [63:0] raw, input logic [2:0] code,
                                            input logic flt);
        logic [31:0] r;
        r = 32'd0;
        if (flt)
        begin
            case (code)
                WIDTH_32: r = raw[31:0];
                WIDTH_64: r = f64_to_f32(raw);
                default:  r = 32'd0;
            endcase
        end
        else
        begin
            case (code)
                WIDTH_8:  r = raw[7] ? int_to_f32(1'b0, {25'd0, raw[6:0]}, 5'd7)
                                     : int_to_f32(1'b1, 32'd128 - {24'd0, raw[7:0]}, 5'd7);
                WIDTH_16: r = raw[15] ? int_to_f32(1'b1, 32'h10000 - {16'd0, raw[15:0]}, 5'd15)
                                      : int_to_f32(1'b0, {16'd0, raw[15:0]}, 5'd15);
                WIDTH_24: r = raw[23] ? int_to_f32(1'b1, 32'h1000000 - {8'd0, raw[23:0]}, 5'd23)
                                      : int_to_f32(1'b0, {8'd0, raw[23:0]}, 5'd23);
                WIDTH_32: r = raw[31] ? int_to_f32(1'b1, 32'd0 - raw[31:0], 5'd31)
                                      : int_to_f32(1'b0, raw[31:0], 5'd31);
                default:  r = 32'd0;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pcm_bytes_to_float_samples.sv =====
// Top level of the PCM byte to float sample converter.
// Depends on pcmf_pkg.
`default_nettype none
// One byte item is taken every cycle. A byte that completes a sample is
// registered with the sample bytes, converted by the logic after that
// register, and the float32 result moves into the output register when that
// register is free; the input stays open while a result waits, and only a full
// output register with a complete sample behind it stalls the byte stream.
module pcm_bytes_to_float_samples
    import pcmf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte [7:0]
    input  wire logic        s_tlast,   // end_of_data
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // sample_value [31:0], channel_index [34:32], zeros
    output logic             m_tlast    // frame_end
);

    logic [2:0]  width_reg;
    logic        float_reg;
    logic [3:0]  chans_reg;
    logic [63:0] asm_reg, asm_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  chan_reg, chan_next;
    // Stage one: assembled sample awaiting conversion.
    logic        s1_valid_reg;
    logic [63:0] s1_raw_reg;
    logic [2:0]  s1_code_reg;
    logic        s1_flt_reg;
    logic [2:0]  s1_chan_reg;
    logic        s1_fend_reg;
    // Output register.
    logic        out_valid_reg;
    logic [31:0] out_val_reg;
    logic [2:0]  out_chan_reg;
    logic        out_fend_reg;

    logic        acc;
    logic        done;
    logic        fend;
    logic [3:0]  need;
    logic [3:0]  chans;
    logic [3:0]  cnt_inc;
    logic [63:0] merged;
    logic [63:0] raw_masked;
    logic        s1_move;
    logic        out_free;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_16;
            float_reg <= 1'b0;
            chans_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH: width_reg <= cfg_data[2:0];
                REG_FLOAT: float_reg <= cfg_data[0];
                REG_CHANS: chans_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Handshake: stage one drains when the output register is free.
    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign acc      = s_tvalid && s_tready;

    // Byte assembly and sample completion.
    always_comb
    begin
        need = width_bytes(width_reg);
        chans = (chans_reg == 4'd0) ? 4'd1 :
                (chans_reg > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : chans_reg;
        merged = asm_reg | ({56'd0, s_tdata} << {cnt_reg, 3'b000});
        cnt_inc = {1'b0, cnt_reg} + 4'd1;
        done = (need != 4'd0) && (cnt_inc >= need);
        fend = ({1'b0, chan_reg} + 4'd1) >= chans;
        raw_masked = merged;
        if (need < 4'd8)
            raw_masked = merged & ~(64'hFFFF_FFFF_FFFF_FFFF << {need[2:0], 3'b000});
        asm_next = asm_reg;
        cnt_next = cnt_reg;
        chan_next = chan_reg;
        if (need == 4'd0 || done)
        begin
            asm_next = 64'd0;
            cnt_next = 3'd0;
        end
        else
        begin
            asm_next = merged;
            cnt_next = cnt_inc[2:0];
        end
        if (done)
            chan_next = fend ? 3'd0 : chan_reg + 3'd1;
        if (s_tlast)
        begin
            asm_next = 64'd0;
            cnt_next = 3'd0;
            chan_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asm_reg <= 64'd0;
            cnt_reg <= 3'd0;
            chan_reg <= 3'd0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                asm_reg <= asm_next;
                cnt_reg <= cnt_next;
                chan_reg <= chan_next;
            end
            if (acc)
                s1_valid_reg <= done;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (acc && done)
        begin
            s1_raw_reg <= raw_masked;
            s1_code_reg <= width_reg;
            s1_flt_reg <= float_reg;
            s1_chan_reg <= chan_reg;
            s1_fend_reg <= fend;
        end
        if (s1_move)
        begin
            out_val_reg <= convert(s1_raw_reg, s1_code_reg, s1_flt_reg);
            out_chan_reg <= s1_chan_reg;
            out_fend_reg <= s1_fend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_chan_reg, out_val_reg};
    assign m_tlast  = out_fend_reg;

endmodule
`default_nettype wire

// ===== hdl/pcmf_checker.sv =====
// Port-level checker for the converter, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pcmf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);
    // A stalled result holds.
    `CHK_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    // Padding bits stay zero.
    `CHK_IMPLY(a_pad, clk, rst_n, m_tvalid, m_tdata[39:35] == 5'd0, "padding bits set")
    // Input is open whenever the output is being drained.
    `CHK_IMPLY(a_open, clk, rst_n, m_tready, s_tready, "input stalled while output drains")
    // A result on the top channel index always ends a frame.
    `CHK_IMPLY(a_top, clk, rst_n, m_tvalid && m_tdata[34:32] == 3'd7, m_tlast, "channel 7 not frame end")
endmodule

bind pcm_bytes_to_float_samples pcmf_checker u_pcmf_checker
(
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
